/* sv/dire_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dire_pkg;

  // Frame limits used as defaults for the top level
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Field widths
  localparam int PIXEL_W    = 8;
  localparam int RES_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Register reset values
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Largest pixel value, upper clamp of the prediction
  localparam int PIX_MAX = 255;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

/* sv/dire_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pixel word channel
interface dire_pixel_if
  import dire_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// Residual word channel
interface dire_residual_if
  import dire_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] residual;
  logic                    frame_end;

  modport source (output valid, output residual, output frame_end, input ready);
  modport sink   (input valid, input residual, input frame_end, output ready);
endinterface

// Register write channel
interface dire_cfg_if
  import dire_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/dire_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module dire_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/dpcm_image_residual_encoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                          Word
// pix_in    in   pixel[7:0]                       one grey pixel, raster order
// res_out   out  residual[8:0] s, frame_end       one residual per pixel
// cfg       in   index[1:0], data[11:0]           register write, always ready
//
// One pixel per cycle unless the output stalls: the line store is read when a
// pixel is taken and written as it leaves stage 1, one read and one write port
// per cycle. The residual is valid after the stage 1 and output registers.
// Synchronous reset clears counters and neighbors and sets sizes (640 x 480).
// A stalled output holds the middle stage, which then blocks pix_in.
module dpcm_image_residual_encoder_core
  import dire_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input wire logic         clk,
  input wire logic         rst,
  dire_pixel_if.sink       pix_in,
  dire_residual_if.source  res_out,
  dire_cfg_if.sink         cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RST_W_M1 = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH - 1 : RESET_WIDTH - 1;
  localparam int RST_H_M1 = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT - 1 : RESET_HEIGHT - 1;
  localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
  localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);

  // Effective size minus one: zero acts as one, oversize clamps to the limit
  function automatic logic [31:0] size_m1(input logic [CFG_DATA_W-1:0] val,
                                          input logic [31:0] limit);
    logic [31:0] v;
    v = 32'(val);
    if (v == 32'd0) begin
      return 32'd0;
    end else if (v > limit) begin
      return limit - 32'd1;
    end
    return v - 32'd1;
  endfunction

  // Sizes, stored as last column and last row
  logic [CW-1:0] width_m1;
  logic [RW-1:0] height_m1;
  logic [31:0]   cfg_w_m1;
  logic [31:0]   cfg_h_m1;

  assign cfg.ready = 1'b1;
  assign cfg_w_m1  = size_m1(cfg.data, MAX_W32);
  assign cfg_h_m1  = size_m1(cfg.data, MAX_H32);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1  <= CW'(RST_W_M1);
      height_m1 <= RW'(RST_H_M1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  width_m1  <= cfg_w_m1[CW-1:0];
        REG_IMAGE_HEIGHT: height_m1 <= cfg_h_m1[RW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid;
  logic s1_adv;
  logic in_take;
  logic out_valid;

  assign s1_adv       = s1_valid && (!out_valid || res_out.ready);
  assign pix_in.ready = !s1_valid || s1_adv;
  assign in_take      = pix_in.valid && pix_in.ready;

  // Raster counters
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          last_col;
  logic          last_row;

  assign last_col = (col >= width_m1);
  assign last_row = (row >= height_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_take) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Line store: read at accept, written back when the pixel leaves stage 1
  logic [CW-1:0]      s1_col;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [PIXEL_W-1:0] ram_rdata;

  dire_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_pixel),
    .re    (in_take),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // Stage 1 registers
  logic               s1_row0;
  logic               s1_col0;
  logic               s1_end;
  logic               s1_fwd;
  logic [PIXEL_W-1:0] s1_fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // A one-pixel-wide row reads the entry being written this cycle: forward it
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pixel    <= pix_in.pixel;
      s1_col      <= col;
      s1_row0     <= (row == '0);
      s1_col0     <= (col == '0);
      s1_end      <= last_col && last_row;
      s1_fwd      <= s1_adv && (s1_col == col);
      s1_fwd_data <= s1_pixel;
    end
  end

  // Neighbors
  logic [PIXEL_W-1:0] left_pixel;
  logic [PIXEL_W-1:0] above_left_pixel;
  logic [PIXEL_W-1:0] above;

  assign above = s1_fwd ? s1_fwd_data : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      above_left_pixel <= '0;
    end else if (s1_adv) begin
      left_pixel       <= s1_pixel;
      above_left_pixel <= above;
    end
  end

  // Prediction and residual
  logic signed [PIXEL_W:0]   diff;
  logic signed [PIXEL_W:0]   half;
  logic signed [PIXEL_W+1:0] pred_raw;
  logic        [PIXEL_W-1:0] pred;
  logic signed [RES_W-1:0]   residual;

  always_comb begin
    diff     = $signed({1'b0, above}) - $signed({1'b0, above_left_pixel});
    // halve, truncating toward zero
    half     = (diff + $signed({{PIXEL_W{1'b0}}, diff[PIXEL_W]})) >>> 1;
    pred_raw = {half[PIXEL_W], half} + $signed({2'b00, left_pixel});
    if (s1_row0) begin
      pred = s1_col0 ? '0 : left_pixel;
    end else if (s1_col0) begin
      pred = above;
    end else if (pred_raw < 0) begin
      pred = '0;
    end else if (pred_raw > (PIXEL_W+2)'(PIX_MAX)) begin
      pred = PIXEL_W'(PIX_MAX);
    end else begin
      pred = pred_raw[PIXEL_W-1:0];
    end
    residual = $signed({1'b0, s1_pixel}) - $signed({1'b0, pred});
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_out.residual  <= residual;
      res_out.frame_end <= s1_end;
    end
  end

  assign res_out.valid = out_valid;

endmodule

`default_nettype wire
